>>> src/wsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;
	localparam int SCREEN_COORD_BITS_DEF = 16;
	localparam int COEF_FRAC_BITS_DEF    = 24;
	localparam int POINT_FRAC_BITS       = 16;
	localparam int NUM_COEFS             = 12;
	localparam int NUM_ROWS              = 3;
	localparam int W_MIN_Q16             = 66;
	localparam int DIM_BITS              = 14;
	localparam int IDX_BITS              = 4;
	localparam int VAL_BITS              = 32;
	localparam int CFG_IDX_BITS          = 4;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 14'd1920;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 14'd1080;

	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 4'd1;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_PROJECT = 1'b1;

	typedef struct packed {
		logic [DIM_BITS-1:0] width;
		logic [DIM_BITS-1:0] height;
	} viewport_t;
endpackage
`default_nettype wire

>>> src/wsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wsp_item_if;
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic [wsp_pkg::IDX_BITS-1:0]      coef_index;
	logic signed [wsp_pkg::VAL_BITS-1:0] coef_value;
	logic signed [wsp_pkg::VAL_BITS-1:0] world_x;
	logic signed [wsp_pkg::VAL_BITS-1:0] world_y;
	logic signed [wsp_pkg::VAL_BITS-1:0] world_z;
	modport source (output valid, action, coef_index, coef_value, world_x, world_y, world_z,
		input ready);
	modport sink (input valid, action, coef_index, coef_value, world_x, world_y, world_z,
		output ready);
endinterface

interface wsp_result_if #(parameter int B = wsp_pkg::SCREEN_COORD_BITS_DEF);
	logic                valid;
	logic                ready;
	logic                visible;
	logic signed [B-1:0] screen_x;
	logic signed [B-1:0] screen_y;
	modport source (output valid, visible, screen_x, screen_y, input ready);
	modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface wsp_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wsp_pkg::CFG_IDX_BITS-1:0]    index;
	logic [wsp_pkg::VAL_BITS-1:0]        data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/world_to_screen_projection_unit.sv
// channel | dir | payload                                       | transfer
// item    | in  | action, coef_index, coef_value, world_x/y/z   | valid && ready
// result  | out | visible, screen_x, screen_y                   | valid && ready
// cfg     | in  | index, data (0 screen_width, 1 screen_height) | valid && ready, ready always 1
// one item per cycle while result is not stalled; a project item passes through two
// dot product stages, two viewport stages, one divide setup stage and one divide
// stage per output bit; a load item writes its coefficient at transfer
// reset clears coefficients and all stage valid bits and sets the viewport to 1920 x 1080
// a stall on result holds the last stage; each stage takes data while it is empty or its data moves on
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_unit #(
	parameter int SCREEN_COORD_BITS = wsp_pkg::SCREEN_COORD_BITS_DEF,
	parameter int COEF_FRAC_BITS    = wsp_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wsp_item_if.sink  item,
	wsp_result_if.source result,
	wsp_cfg_if.sink   cfg
);
	localparam int B  = SCREEN_COORD_BITS;
	localparam int SW = 66 - COEF_FRAC_BITS;
	localparam int NW = SW + 17;

	wsp_pkg::viewport_t vp_q;
	logic                 take, load, en_dot, en_map, en_div;
	logic                 v2, v4, vis4;
	logic signed [SW-1:0] x2, y2, w2;
	logic signed [NW-1:0] nx4, ny4;
	logic [SW:0]          den4;
	logic                 vis_f, negx_f, negy_f, ovfx_f, ovfy_f;
	logic [B-1:0]         qx_f, qy_f;

	assign item.ready = en_dot;
	assign take = item.valid && item.ready && (item.action == wsp_pkg::ACT_PROJECT);
	assign load = item.valid && item.ready && (item.action == wsp_pkg::ACT_LOAD);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q.width  <= wsp_pkg::WIDTH_RESET;
			vp_q.height <= wsp_pkg::HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				wsp_pkg::CFG_WIDTH:  vp_q.width  <= cfg.data[wsp_pkg::DIM_BITS-1:0];
				wsp_pkg::CFG_HEIGHT: vp_q.height <= cfg.data[wsp_pkg::DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	wsp_dot #(.CFB(COEF_FRAC_BITS), .SW(SW)) u_dot (
		.clk(clk), .arst_n(arst_n),
		.wr_en(load), .wr_idx(item.coef_index), .wr_val(item.coef_value),
		.take(take), .px(item.world_x), .py(item.world_y), .pz(item.world_z),
		.down_en(en_map), .up_en(en_dot),
		.v_out(v2), .x_out(x2), .y_out(y2), .w_out(w2)
	);

	wsp_map #(.SW(SW), .NW(NW)) u_map (
		.clk(clk), .arst_n(arst_n), .vp(vp_q),
		.v_in(v2), .x_in(x2), .y_in(y2), .w_in(w2),
		.down_en(en_div), .up_en(en_map),
		.v_out(v4), .vis_out(vis4), .nx_out(nx4), .ny_out(ny4), .den_out(den4)
	);

	wsp_div #(.B(B), .SW(SW), .NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n),
		.v_in(v4), .vis_in(vis4), .nx_in(nx4), .ny_in(ny4), .den_in(den4),
		.down_en(result.ready), .up_en(en_div),
		.v_out(result.valid), .vis_out(vis_f),
		.negx_out(negx_f), .negy_out(negy_f), .ovfx_out(ovfx_f), .ovfy_out(ovfy_f),
		.qx_out(qx_f), .qy_out(qy_f)
	);

	localparam logic [B-1:0] HALF = B'(1) << (B - 1);
	localparam logic [B-1:0] HI   = HALF - B'(1);

	function automatic logic [B-1:0] sat(input logic neg, input logic ovf,
		input logic [B-1:0] q);
		logic [B-1:0] r;
		if (!neg) r = (ovf || q[B-1]) ? HI : q;
		else r = (ovf || (q > HALF)) ? HALF : B'(-q);
		return r;
	endfunction

	assign result.visible  = vis_f;
	assign result.screen_x = vis_f ? $signed(sat(negx_f, ovfx_f, qx_f)) : '0;
	assign result.screen_y = vis_f ? $signed(sat(negy_f, ovfy_f, qy_f)) : '0;
endmodule
`default_nettype wire

>>> src/wsp_dot.sv
`timescale 1ns / 1ps
`default_nettype none
module wsp_dot #(
	parameter int CFB = wsp_pkg::COEF_FRAC_BITS_DEF,
	parameter int SW  = 66 - CFB
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [wsp_pkg::IDX_BITS-1:0]         wr_idx,
	input  wire logic signed [wsp_pkg::VAL_BITS-1:0]  wr_val,
	input  wire logic                                 take,
	input  wire logic signed [wsp_pkg::VAL_BITS-1:0]  px,
	input  wire logic signed [wsp_pkg::VAL_BITS-1:0]  py,
	input  wire logic signed [wsp_pkg::VAL_BITS-1:0]  pz,
	input  wire logic                                 down_en,
	output logic                                      up_en,
	output logic                                      v_out,
	output logic signed [SW-1:0]                      x_out,
	output logic signed [SW-1:0]                      y_out,
	output logic signed [SW-1:0]                      w_out
);
	localparam int NR = wsp_pkg::NUM_ROWS;
	localparam int VB = wsp_pkg::VAL_BITS;

	logic signed [VB-1:0]   coef_q [wsp_pkg::NUM_COEFS];
	logic signed [2*VB-1:0] prod_s1 [NR*3];
	logic signed [VB-1:0]   cst_s1 [NR];
	logic                   v_s1;
	logic signed [SW-1:0]   sum_s2 [NR];
	logic                   v_s2;
	logic                   en1;
	logic                   en2;
	logic signed [VB-1:0]   pt [3];
	logic signed [SW-1:0]   sum [NR];

	assign en2   = !v_s2 || down_en;
	assign en1   = !v_s1 || en2;
	assign up_en = en1;
	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsp_pkg::NUM_COEFS; i++) coef_q[i] <= '0;
		end else if (wr_en && (wr_idx < wsp_pkg::IDX_BITS'(wsp_pkg::NUM_COEFS))) begin
			coef_q[wr_idx] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= take;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int r = 0; r < NR; r++) begin
				for (int c = 0; c < 3; c++) prod_s1[r*3+c] <= coef_q[r*4+c] * pt[c];
				cst_s1[r] <= coef_q[r*4+3] >>> (CFB - wsp_pkg::POINT_FRAC_BITS);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < NR; r++) begin
			sum[r] = SW'(prod_s1[r*3] >>> CFB) + SW'(prod_s1[r*3+1] >>> CFB)
				+ SW'(prod_s1[r*3+2] >>> CFB) + SW'(cst_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int r = 0; r < NR; r++) sum_s2[r] <= sum[r];
		end
	end

	assign v_out = v_s2;
	assign x_out = sum_s2[0];
	assign y_out = sum_s2[1];
	assign w_out = sum_s2[2];
endmodule
`default_nettype wire

>>> src/wsp_map.sv
`timescale 1ns / 1ps
`default_nettype none
module wsp_map #(
	parameter int SW = 42,
	parameter int NW = SW + 17
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wsp_pkg::viewport_t    vp,
	input  wire logic                  v_in,
	input  wire logic signed [SW-1:0]  x_in,
	input  wire logic signed [SW-1:0]  y_in,
	input  wire logic signed [SW-1:0]  w_in,
	input  wire logic                  down_en,
	output logic                       up_en,
	output logic                       v_out,
	output logic                       vis_out,
	output logic signed [NW-1:0]       nx_out,
	output logic signed [NW-1:0]       ny_out,
	output logic [SW:0]                den_out
);
	localparam int PW = SW + 16;
	localparam int DB = wsp_pkg::DIM_BITS;

	logic signed [PW-1:0] mx_s3, my_s3, wx_s3, wy_s3;
	logic signed [SW-1:0] w_s3;
	logic                 vis_s3, v_s3;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic [SW:0]          den_s4;
	logic                 vis_s4, v_s4;
	logic                 en3, en4;
	logic signed [15:0]   kx, ky;
	logic signed [DB:0]   sw, sh;

	assign en4   = !v_s4 || down_en;
	assign en3   = !v_s3 || en4;
	assign up_en = en3;
	assign kx    = $signed({2'b00, vp.width[DB-1:1], 1'b1});
	assign ky    = $signed({2'b00, vp.height[DB-1:1], 1'b0}) - 16'sd1;
	assign sw    = $signed({1'b0, vp.width});
	assign sh    = $signed({1'b0, vp.height});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en3) v_s3 <= v_in;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			mx_s3  <= x_in * sw;
			my_s3  <= y_in * sh;
			wx_s3  <= w_in * kx;
			wy_s3  <= w_in * ky;
			w_s3   <= w_in;
			vis_s3 <= w_in >= SW'(wsp_pkg::W_MIN_Q16);
		end
		if (en4) begin
			nx_s4  <= NW'(wx_s3) + NW'(mx_s3);
			ny_s4  <= NW'(wy_s3) - NW'(my_s3);
			den_s4 <= {w_s3, 1'b0};
			vis_s4 <= vis_s3;
		end
	end

	assign v_out   = v_s4;
	assign vis_out = vis_s4;
	assign nx_out  = nx_s4;
	assign ny_out  = ny_s4;
	assign den_out = den_s4;
endmodule
`default_nettype wire

>>> src/wsp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wsp_div #(
	parameter int B  = wsp_pkg::SCREEN_COORD_BITS_DEF,
	parameter int SW = 42,
	parameter int NW = SW + 17
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  v_in,
	input  wire logic                  vis_in,
	input  wire logic signed [NW-1:0]  nx_in,
	input  wire logic signed [NW-1:0]  ny_in,
	input  wire logic [SW:0]           den_in,
	input  wire logic                  down_en,
	output logic                       up_en,
	output logic                       v_out,
	output logic                       vis_out,
	output logic                       negx_out,
	output logic                       negy_out,
	output logic                       ovfx_out,
	output logic                       ovfy_out,
	output logic [B-1:0]               qx_out,
	output logic [B-1:0]               qy_out
);
	localparam int CW = NW + B + 1;

	logic [NW-1:0] rx [B+1];
	logic [NW-1:0] ry [B+1];
	logic [B-1:0]  qx [B+1];
	logic [B-1:0]  qy [B+1];
	logic [SW:0]   d  [B+1];
	logic          v    [B+1];
	logic          vis  [B+1];
	logic          negx [B+1];
	logic          negy [B+1];
	logic          ovfx [B+1];
	logic          ovfy [B+1];
	logic [B+1:0]  en;
	logic [NW-1:0] magx, magy;
	logic [CW-1:0] dtop;

	assign en[B+1] = down_en;
	assign up_en   = en[0];
	assign magx    = nx_in[NW-1] ? NW'(-nx_in) : NW'(nx_in);
	assign magy    = ny_in[NW-1] ? NW'(-ny_in) : NW'(ny_in);
	assign dtop    = CW'(den_in) << B;

	for (genvar k = 0; k <= B; k++) begin : g_en
		assign en[k] = !v[k] || en[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[k] <= 1'b0;
			else if (en[k]) v[k] <= (k == 0) ? v_in : v[(k == 0) ? 0 : k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rx[0]   <= magx;
			ry[0]   <= magy;
			qx[0]   <= '0;
			qy[0]   <= '0;
			d[0]    <= den_in;
			vis[0]  <= vis_in;
			negx[0] <= nx_in[NW-1];
			negy[0] <= ny_in[NW-1];
			ovfx[0] <= CW'(magx) >= dtop;
			ovfy[0] <= CW'(magy) >= dtop;
		end
	end

	for (genvar k = 1; k <= B; k++) begin : g_step
		localparam int BIT = B - k;
		logic [CW-1:0] dk;
		logic          gx, gy;
		assign dk = CW'(d[k-1]) << BIT;
		assign gx = CW'(rx[k-1]) >= dk;
		assign gy = CW'(ry[k-1]) >= dk;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rx[k]   <= gx ? NW'(CW'(rx[k-1]) - dk) : rx[k-1];
				ry[k]   <= gy ? NW'(CW'(ry[k-1]) - dk) : ry[k-1];
				qx[k]   <= qx[k-1] | (B'(gx) << BIT);
				qy[k]   <= qy[k-1] | (B'(gy) << BIT);
				d[k]    <= d[k-1];
				vis[k]  <= vis[k-1];
				negx[k] <= negx[k-1];
				negy[k] <= negy[k-1];
				ovfx[k] <= ovfx[k-1];
				ovfy[k] <= ovfy[k-1];
			end
		end
	end

	assign v_out    = v[B];
	assign vis_out  = vis[B];
	assign negx_out = negx[B];
	assign negy_out = negy[B];
	assign ovfx_out = ovfx[B];
	assign ovfy_out = ovfy[B];
	assign qx_out   = qx[B];
	assign qy_out   = qy[B];
endmodule
`default_nettype wire

>>> src/wsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module wsp_checker #(
	parameter int B = wsp_pkg::SCREEN_COORD_BITS_DEF
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         item_ready,
	input wire logic         res_valid,
	input wire logic         res_ready,
	input wire logic         res_visible,
	input wire logic [B-1:0] res_x,
	input wire logic [B-1:0] res_y,
	input wire logic         cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_y)
		&& $stable(res_visible))
		else $error("stalled result changed");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_visible |-> res_x == '0 && res_y == '0)
		else $error("hidden point with nonzero coordinates");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("input stalled with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");
endmodule

bind world_to_screen_projection_unit wsp_checker #(.B(SCREEN_COORD_BITS)) u_wsp_checker (
	.clk(clk), .arst_n(arst_n), .item_ready(item.ready),
	.res_valid(result.valid), .res_ready(result.ready), .res_visible(result.visible),
	.res_x(result.screen_x), .res_y(result.screen_y), .cfg_ready(cfg.ready)
);
`default_nettype wire

>>> tb/tb_world_to_screen_projection_unit.sv
`timescale 1ns / 1ps
module tb_world_to_screen_projection_unit;
	import wsp_pkg::*;

	typedef struct packed {
		logic        action;
		logic [3:0]  coef_index;
		logic [31:0] coef_value;
		logic [31:0] world_x;
		logic [31:0] world_y;
		logic [31:0] world_z;
	} point_cmd_t;

	typedef struct packed {
		logic        visible;
		logic [15:0] screen_x;
		logic [15:0] screen_y;
	} pixel_t;

	typedef struct {
		point_cmd_t cmd;
		logic       has_pixel;
		pixel_t     pixel;
	} table_row_t;

	localparam int LATENCY = SCREEN_COORD_BITS_DEF + 5;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;

	wsp_item_if item ();
	wsp_result_if result ();
	wsp_cfg_if cfg ();

	world_to_screen_projection_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	logic signed [63:0] coef_mem [NUM_COEFS];
	logic [DIM_BITS-1:0] view_w;
	logic [DIM_BITS-1:0] view_h;
	pixel_t pending_pixels[$];
	int errors;
	int n_points;
	int n_hidden;
	int n_loads;
	int idle_src_pct;
	int idle_snk_pct;
	int quiet_cycles;
	logic timed_out;

	function automatic logic signed [63:0] floor_q(input logic signed [63:0] v, input int s);
		floor_q = v >>> s;
	endfunction

	function automatic logic signed [63:0] row_dot(input int row, input logic signed [63:0] px,
		input logic signed [63:0] py, input logic signed [63:0] pz);
		logic signed [63:0] acc;
		acc = floor_q(coef_mem[row*4] * px, COEF_FRAC_BITS_DEF);
		acc += floor_q(coef_mem[row*4+1] * py, COEF_FRAC_BITS_DEF);
		acc += floor_q(coef_mem[row*4+2] * pz, COEF_FRAC_BITS_DEF);
		acc += floor_q(coef_mem[row*4+3], COEF_FRAC_BITS_DEF - POINT_FRAC_BITS);
		return acc;
	endfunction

	function automatic logic [15:0] clamp_pixel(input logic signed [63:0] v);
		if (v > 64'sd32767)
			return 16'h7fff;
		if (v < -64'sd32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	// returns 1 when the command yields a pixel
	function automatic logic project_cmd(input point_cmd_t c, output pixel_t p);
		logic signed [63:0] px, py, pz, x, y, w, wd, ht, hw, hh, den;
		p = '0;
		if (c.action == ACT_LOAD) begin
			if (c.coef_index < NUM_COEFS)
				coef_mem[c.coef_index] = {{32{c.coef_value[31]}}, c.coef_value};
			return 1'b0;
		end
		px = {{32{c.world_x[31]}}, c.world_x};
		py = {{32{c.world_y[31]}}, c.world_y};
		pz = {{32{c.world_z[31]}}, c.world_z};
		x = row_dot(0, px, py, pz);
		y = row_dot(1, px, py, pz);
		w = row_dot(2, px, py, pz);
		if (w < W_MIN_Q16)
			return 1'b1;
		wd = {50'd0, view_w};
		ht = {50'd0, view_h};
		hw = wd / 2;
		hh = ht / 2;
		den = 2 * w;
		p.visible = 1'b1;
		p.screen_x = clamp_pixel((2 * hw * w + x * wd + w) / den);
		p.screen_y = clamp_pixel((2 * hh * w - y * ht - w) / den);
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
			3: return $urandom;
			default: return $signed($urandom_range(0, 400000)) - 32'sd200000;
		endcase
	endfunction

	function automatic point_cmd_t rand_point();
		point_cmd_t c;
		c = '0;
		c.action = ACT_PROJECT;
		c.coef_index = 4'($urandom);
		c.coef_value = $urandom;
		c.world_x = rand_word();
		c.world_y = rand_word();
		c.world_z = rand_word();
		return c;
	endfunction

	function automatic point_cmd_t rand_load(input int idx);
		point_cmd_t c;
		c = '0;
		c.action = ACT_LOAD;
		c.coef_index = 4'(idx);
		c.world_x = $urandom;
		c.world_y = $urandom;
		c.world_z = $urandom;
		case ($urandom_range(0, 3))
			0: c.coef_value = $urandom;
			1: c.coef_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: c.coef_value = $signed($urandom_range(0, 1 << 25)) - 32'sd16777216;
		endcase
		return c;
	endfunction

	task automatic send_cmd(input point_cmd_t c);
		pixel_t p;
		while ($urandom_range(0, 99) < idle_src_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.action <= c.action;
		item.coef_index <= c.coef_index;
		item.coef_value <= c.coef_value;
		item.world_x <= c.world_x;
		item.world_y <= c.world_y;
		item.world_z <= c.world_z;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		if (project_cmd(c, p)) begin
			pending_pixels.push_back(p);
			n_points++;
			if (!p.visible)
				n_hidden++;
		end else begin
			n_loads++;
		end
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (pending_pixels.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (LATENCY + 4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [13:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= {18'd0, val};
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		if (idx == CFG_WIDTH)
			view_w = val;
		else if (idx == CFG_HEIGHT)
			view_h = val;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: sink stalls and scoreboard
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n) begin
			result.ready <= ($urandom_range(0, 99) >= idle_snk_pct);
			if (result.valid && result.ready) begin
				got.visible = result.visible;
				got.screen_x = result.screen_x;
				got.screen_y = result.screen_y;
				if (pending_pixels.size() == 0) begin
					$display("%0t unexpected transfer: expected none actual %h", $time, got);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					if (got.visible !== want.visible) begin
						$display("%0t visible: expected %0b actual %0b", $time,
							want.visible, got.visible);
						errors++;
					end
					if (got.screen_x !== want.screen_x) begin
						$display("%0t screen_x: expected %0d actual %0d", $time,
							$signed(want.screen_x), $signed(got.screen_x));
						errors++;
					end
					if (got.screen_y !== want.screen_y) begin
						$display("%0t screen_y: expected %0d actual %0d", $time,
							$signed(want.screen_y), $signed(got.screen_y));
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready)
			|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic table_row_t mk(input logic act, input logic [3:0] idx,
		input logic [31:0] cv, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic has, input pixel_t p);
		table_row_t r;
		r.cmd = '{act, idx, cv, x, y, z};
		r.has_pixel = has;
		r.pixel = p;
		return r;
	endfunction

	table_row_t directed[$];

	task automatic run_directed();
		pixel_t p;
		logic known;
		directed.delete();
		// all-zero matrix: w = 0, hidden
		directed.push_back(mk(ACT_PROJECT, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 1, '0));
		directed.push_back(mk(ACT_PROJECT, 4'hf, 32'hffff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'hffff_ffff, 1, '0));
		// w just below threshold: W = 65
		directed.push_back(mk(ACT_LOAD, 11, 32'd65 << 8, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 0, 0, 0, 1, '0));
		// w = 66: visible, centered
		directed.push_back(mk(ACT_LOAD, 11, 32'd66 << 8, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 0, 0, 0, 0, '0));
		// out of range slots are ignored
		directed.push_back(mk(ACT_LOAD, 12, 32'h8000_0000, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 15, 32'h7fff_ffff, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 0, 0, 0, 0, '0));
		// w = 1.0, identity x and y
		directed.push_back(mk(ACT_LOAD, 11, 32'h0100_0000, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 0, 32'h0100_0000, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 5, 32'h0100_0000, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 32'h0001_0000, 32'hffff_0000, 0, 0, '0));
		// huge x and y saturate
		directed.push_back(mk(ACT_PROJECT, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1,
			'{1'b1, 16'h7fff, 16'h8000}));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 1,
			'{1'b1, 16'h8000, 16'h7fff}));
		// extreme z coefficients on x and w rows
		directed.push_back(mk(ACT_LOAD, 2, 32'h8000_0000, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_LOAD, 10, 32'h7fff_ffff, 0, 0, 0, 0, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 0, 0, 32'h0002_0000, 0, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 0, 0, 32'h8000_0000, 1, '0));
		directed.push_back(mk(ACT_PROJECT, 0, 0, 32'hffff_ffff, 32'hffff_ffff,
			32'h7fff_ffff, 0, '0));
		foreach (directed[i]) begin
			known = directed[i].has_pixel;
			send_cmd(directed[i].cmd);
			if (known && directed[i].cmd.action == ACT_PROJECT) begin
				p = pending_pixels[pending_pixels.size()-1];
				if (p !== directed[i].pixel) begin
					$display("%0t table row %0d: expected %h actual %h", $time, i,
						directed[i].pixel, p);
					errors++;
				end
			end
		end
	endtask

	task automatic random_phase(input int count);
		int k;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 4) == 0) begin
				// fresh matrix, well-formed set of loads
				for (int i = 0; i < NUM_COEFS; i++)
					send_cmd(rand_load(i));
				k += NUM_COEFS;
			end else if ($urandom_range(0, 9) == 0) begin
				send_cmd(rand_load($urandom_range(0, 15)));
				k++;
			end else begin
				send_cmd(rand_point());
				k++;
			end
		end
	endtask

	task automatic set_view(input logic [13:0] wd, input logic [13:0] ht);
		drain();
		write_reg(CFG_WIDTH, wd);
		write_reg(CFG_HEIGHT, ht);
	endtask

	initial begin
		errors = 0;
		n_points = 0;
		n_hidden = 0;
		n_loads = 0;
		timed_out = 1'b0;
		idle_src_pct = 29;
		idle_snk_pct = 87;
		view_w = WIDTH_RESET;
		view_h = HEIGHT_RESET;
		for (int i = 0; i < NUM_COEFS; i++)
			coef_mem[i] = 0;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.action = ACT_LOAD;
		item.coef_index = '0;
		item.coef_value = '0;
		item.world_x = '0;
		item.world_y = '0;
		item.world_z = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		random_phase(250);
		set_view(14'd8192, 14'd1);
		random_phase(150);
		set_view(14'd0, 14'd0);
		random_phase(100);

		idle_src_pct = 87;
		idle_snk_pct = 29;
		set_view(14'd1, 14'd8192);
		random_phase(150);
		set_view(14'd16383, 14'd16383);
		random_phase(150);
		set_view(14'd1920, 14'd1080);
		random_phase(150);

		idle_src_pct = 0;
		idle_snk_pct = 0;
		set_view(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
		random_phase(175);
		set_view(14'd7, 14'd3);
		random_phase(175);

		drain();
		$display("covered %0d points (%0d hidden) and %0d coefficient loads", n_points,
			n_hidden, n_loads);
		$display("viewports from 0 to 16383 pixels, three idle patterns");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
